// ===== sv/zip_legacy_byte_stream_cipher_unit_macros.svh =====
// assertion macros shared by the cipher unit
`ifndef ZIP_LEGACY_BYTE_STREAM_CIPHER_UNIT_MACROS_SVH
`define ZIP_LEGACY_BYTE_STREAM_CIPHER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define ZLBSC_ASSERT_IMPLIES(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("zlbsc assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define ZLBSC_ASSERT_NEXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error("zlbsc assertion failed");

`endif

// ===== sv/zlbsc_pkg.sv =====
package zlbsc_pkg;

   localparam logic [31:0] START_KEY_A = 32'd305419896;
   localparam logic [31:0] START_KEY_B = 32'd591751049;
   localparam logic [31:0] START_KEY_C = 32'd878082192;
   localparam logic [31:0] LCG_MULT    = 32'd134775813;
   localparam logic [31:0] CRC_POLY    = 32'hEDB88320;

   // queue depth, a power of two
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ABSORB = 2'd1,
      OP_DATA   = 2'd2,
      OP_IGNORE = 2'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_head_type;

   // reflected crc-32 table entry
   function automatic logic [31:0] crc_table(input logic [7:0] idx);
      logic [31:0] t;
      t = {24'd0, idx};
      for (int i = 0; i < 8; i++) begin
         if (t[0]) begin
            t = (t >> 1) ^ CRC_POLY;
         end else begin
            t = t >> 1;
         end
      end
      return t;
   endfunction

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      return crc_table(crc[7:0] ^ b) ^ {8'd0, crc[31:8]};
   endfunction

endpackage

// ===== sv/zip_legacy_byte_stream_cipher_unit.sv =====
// Traditional zip stream cipher, one byte per item. Items pass through a two-entry queue
// into the key engine, which retires a load or a password byte as soon as it reaches the
// queue head and an encrypted data byte once the output register is free, so such items
// stream at one per cycle while the output register is free. A data byte in decrypt mode
// makes a first pass, in which the keystream multiply produces the plaintext and holds it,
// and a second, in which the key update with its crc lookups and 32-bit multiply runs on it.
// A result is written to the output register at the edge where its item leaves the queue,
// which waits for the output register to be free. It can be taken from the next edge on.
// The mode register may change only while the unit holds no item.
`include "zip_legacy_byte_stream_cipher_unit_macros.svh"

module zip_legacy_byte_stream_cipher_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);

   zlbsc_pkg::q_head_type q_head;
   logic                  q_pop;

   zlbsc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .q_head        (q_head),
      .q_pop         (q_pop)
   );

   zlbsc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte)
   );

   `ZLBSC_ASSERT_IMPLIES(a_full_has_head, !req_ready, q_head.valid)
   `ZLBSC_ASSERT_IMPLIES(a_pop_needs_head, q_pop, q_head.valid)
   `ZLBSC_ASSERT_NEXT(a_data_pop_result,
      q_pop && (q_head.item.op == zlbsc_pkg::OP_DATA), rsp_valid)
   `ZLBSC_ASSERT_IMPLIES(a_result_from_pop,
      $rose(rsp_valid), $past(q_pop && (q_head.item.op == zlbsc_pkg::OP_DATA)))

endmodule

// ===== sv/zlbsc_front.sv =====
module zlbsc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_op,
   input  logic [7:0]             req_data_byte,
   output zlbsc_pkg::q_head_type  q_head,
   input  logic                   q_pop
);

   zlbsc_pkg::item_type               entry_ff [zlbsc_pkg::QDEPTH];
   logic [zlbsc_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [zlbsc_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [zlbsc_pkg::QCNT_W-1:0]      count_ff, count_in;
   zlbsc_pkg::op_type                 req_kind;
   logic                              push;
   logic                              pop;

   assign req_kind  = zlbsc_pkg::op_type'(req_op);
   assign req_ready = (count_ff != zlbsc_pkg::QCNT_W'(zlbsc_pkg::QDEPTH));

   // unused op code is taken and dropped here
   assign push = req_valid && req_ready && (req_kind != zlbsc_pkg::OP_IGNORE);
   assign pop  = q_pop && (count_ff != '0);

   assign q_head.valid = (count_ff != '0);
   assign q_head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{op: req_kind, data: req_data_byte};
      end
   end

endmodule

// ===== sv/zlbsc_back.sv =====
module zlbsc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data,
   input  zlbsc_pkg::q_head_type  q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte
);

   logic [31:0] key_a_ff, key_a_in;
   logic [31:0] key_b_ff, key_b_in;
   logic [31:0] key_c_ff, key_c_in;
   logic        encrypt_mode_ff, encrypt_mode_in;
   logic        phase_ff, phase_in;
   logic [7:0]  res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;

   logic [15:0] ks_t;
   logic [15:0] ks_prod;
   logic [7:0]  ks;
   logic [7:0]  data_res;
   logic [7:0]  absorb_byte;
   logic [31:0] a_next;
   logic [31:0] b_sum;
   logic [31:0] b_next;
   logic [31:0] c_next;
   logic        out_free;
   logic        is_data;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_data  = q_head.valid && (q_head.item.op == zlbsc_pkg::OP_DATA);

   // keystream from current key_c
   assign ks_t     = {key_c_ff[15:2], 1'b1, key_c_ff[0]};
   assign ks_prod  = ks_t * (ks_t ^ 16'h0001);
   assign ks       = ks_prod[15:8];
   assign data_res = ks ^ q_head.item.data;

   // decrypted byte comes from the held result of the first pass
   assign absorb_byte = (is_data && !encrypt_mode_ff) ? res_ff : q_head.item.data;

   assign a_next = zlbsc_pkg::crc_byte(key_a_ff, absorb_byte);
   assign b_sum  = key_b_ff + {24'd0, a_next[7:0]};
   assign b_next = (b_sum * zlbsc_pkg::LCG_MULT) + 32'd1;
   assign c_next = zlbsc_pkg::crc_byte(key_c_ff, b_next[31:24]);

   always_comb begin
      q_pop           = 1'b0;
      key_a_in        = key_a_ff;
      key_b_in        = key_b_ff;
      key_c_in        = key_c_ff;
      phase_in        = phase_ff;
      res_in          = res_ff;
      rsp_byte_in     = rsp_byte_ff;
      rsp_valid_in    = rsp_ready ? 1'b0 : rsp_valid_ff;
      encrypt_mode_in = csr_write_enable ? csr_write_data : encrypt_mode_ff;

      if (q_head.valid) begin
         unique case (q_head.item.op)
            zlbsc_pkg::OP_LOAD: begin
               q_pop    = 1'b1;
               key_a_in = zlbsc_pkg::START_KEY_A;
               key_b_in = zlbsc_pkg::START_KEY_B;
               key_c_in = zlbsc_pkg::START_KEY_C;
            end
            zlbsc_pkg::OP_ABSORB: begin
               q_pop    = 1'b1;
               key_a_in = a_next;
               key_b_in = b_next;
               key_c_in = c_next;
            end
            zlbsc_pkg::OP_DATA: begin
               if (!encrypt_mode_ff && !phase_ff) begin
                  res_in   = data_res;
                  phase_in = 1'b1;
               end else if (out_free) begin
                  q_pop        = 1'b1;
                  key_a_in     = a_next;
                  key_b_in     = b_next;
                  key_c_in     = c_next;
                  phase_in     = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = encrypt_mode_ff ? data_res : res_ff;
               end
            end
            default: begin
               q_pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_a_ff        <= zlbsc_pkg::START_KEY_A;
         key_b_ff        <= zlbsc_pkg::START_KEY_B;
         key_c_ff        <= zlbsc_pkg::START_KEY_C;
         encrypt_mode_ff <= 1'b0;
         phase_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         key_a_ff        <= key_a_in;
         key_b_ff        <= key_b_in;
         key_c_ff        <= key_c_in;
         encrypt_mode_ff <= encrypt_mode_in;
         phase_ff        <= phase_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

endmodule
